>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/fdd_pkg.sv
`default_nettype none
package fdd_pkg;

   localparam int SAMPLE_BITS          = 24;
   localparam int DIFF_BITS            = SAMPLE_BITS + 2;
   localparam int SCALE_BITS           = 24;
   localparam int SCALE_FRAC_BITS_DFLT = 16;
   localparam int DERIV_BITS           = 35;
   localparam int SEEN_BITS            = 2;
   localparam int CSR_ADDR_BITS        = 4;
   localparam int CSR_DATA_BITS        = 32;

   localparam logic [SCALE_BITS-1:0] CENTRAL_SCALE_RST = SCALE_BITS'(32768);
   localparam logic [SCALE_BITS-1:0] EDGE_SCALE_RST    = SCALE_BITS'(65536);
   localparam logic [SCALE_BITS-1:0] SECOND_SCALE_RST  = SCALE_BITS'(65536);

   typedef enum logic [1:0] {
      REG_ORDER_MODE    = 2'd0,
      REG_CENTRAL_SCALE = 2'd1,
      REG_EDGE_SCALE    = 2'd2,
      REG_SECOND_SCALE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          stream_end;
   } req_type;

   typedef struct packed {
      logic signed [DERIV_BITS-1:0] derivative;
      logic                         run_last;
      logic                         set_last;
      logic                         short_set;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/finite_difference_derivative_core.sv
// Finite-difference derivative core.
// req_ channel: one sample per item, stream_end marks the last sample of a set.
// rsp_ channel: one derivative per sample index, in index order; run_last flags
// the last result caused by an input item, set_last the result for the final
// index, short_set a set too short for the stencil (value zero).
// csr_ port: APB-style, order_mode at 0x0, central_scale 0x4, edge_scale 0x8,
// second_scale 0xC; pready is tied high, writes land on the access cycle.
// Samples 0 and 1 of a set give no result, sample 2 gives two, later samples
// one, and the final sample one more, so an item gives 0 to 3 results.
// Results of an accepted item wait in the pending slots, then the output register drives rsp_.
// Throughput: one result per cycle while rsp_stall is low, through the single
// shared multiplier; req_stall stays high until all but the last result of an
// item have been emitted, so an item with one or no result is taken every cycle.
// Reset (synchronous) restores the register defaults, empties the window and
// drops all pending results. When rsp_stall is high the output register holds
// and the pending result slots wait; req_stall rises once they are full.
`default_nettype none
`include "assert_macros.svh"

module finite_difference_derivative_core
   import fdd_pkg::*;
#(
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DFLT
) (
   input  wire                      clock,
   input  wire                      reset,
   // input samples
   input  wire                      req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   // results
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output rsp_type                  rsp_data,
   // configuration
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int PROD_BITS = DIFF_BITS + SCALE_BITS + 1;
   localparam int WIDE_BITS = (PROD_BITS > DERIV_BITS) ? PROD_BITS : DERIV_BITS + 1;
   localparam logic signed [WIDE_BITS-1:0] DERIV_MAX =
      WIDE_BITS'({1'b0, {(DERIV_BITS-1){1'b1}}});
   localparam logic signed [WIDE_BITS-1:0] DERIV_MIN = ~DERIV_MAX;

   // one pending result: difference, the scale to apply, and its flags
   typedef struct packed {
      logic signed [DIFF_BITS-1:0] diff;
      logic [SCALE_BITS-1:0]       scale;
      logic                        set_last;
      logic                        short_set;
   } slot_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic                  order_mode_ff;
   logic [SCALE_BITS-1:0] central_scale_ff;
   logic [SCALE_BITS-1:0] edge_scale_ff;
   logic [SCALE_BITS-1:0] second_scale_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff    <= 1'b0;
         central_scale_ff <= CENTRAL_SCALE_RST;
         edge_scale_ff    <= EDGE_SCALE_RST;
         second_scale_ff  <= SECOND_SCALE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ORDER_MODE:    order_mode_ff    <= csr_pwdata[0];
            REG_CENTRAL_SCALE: central_scale_ff <= csr_pwdata[SCALE_BITS-1:0];
            REG_EDGE_SCALE:    edge_scale_ff    <= csr_pwdata[SCALE_BITS-1:0];
            REG_SECOND_SCALE:  second_scale_ff  <= csr_pwdata[SCALE_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ORDER_MODE:    csr_prdata = CSR_DATA_BITS'(order_mode_ff);
         REG_CENTRAL_SCALE: csr_prdata = CSR_DATA_BITS'(central_scale_ff);
         REG_EDGE_SCALE:    csr_prdata = CSR_DATA_BITS'(edge_scale_ff);
         REG_SECOND_SCALE:  csr_prdata = CSR_DATA_BITS'(second_scale_ff);
      endcase
   end

   // ---------------------------------------------------------------------
   // Sample window and set position
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] win0_ff, win1_ff;   // x[i-2], x[i-1]
   logic [SEEN_BITS-1:0]          seen_count_ff;      // 3 means three or more
   logic                          req_accept;

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff       <= '0;
         win1_ff       <= '0;
         seen_count_ff <= '0;
      end else if (req_accept) begin
         if (req_data.stream_end) begin
            win0_ff       <= '0;
            win1_ff       <= '0;
            seen_count_ff <= '0;
         end else begin
            win0_ff <= win1_ff;
            win1_ff <= req_data.sample;
            if (seen_count_ff != '1) seen_count_ff <= seen_count_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result slots for the incoming item
   // ---------------------------------------------------------------------
   logic signed [DIFF_BITS-1:0] s_x, w0_x, w1_x;
   logic signed [DIFF_BITS-1:0] d_central, d_first, d_end, d_second;
   slot_type                    inner_slot, first_slot, end_slot, short_slot;
   slot_type                    slot_in [3];
   logic [1:0]                  count_in;

   assign s_x       = DIFF_BITS'(req_data.sample);
   assign w0_x      = DIFF_BITS'(win0_ff);
   assign w1_x      = DIFF_BITS'(win1_ff);
   assign d_central = s_x - w0_x;
   assign d_first   = w1_x - w0_x;
   assign d_end     = s_x - w1_x;
   assign d_second  = s_x + w0_x - (w1_x <<< 1);

   always_comb begin
      short_slot = '{diff: '0, scale: '0, set_last: 1'b0, short_set: 1'b1};
      if (order_mode_ff) begin
         inner_slot = '{diff: d_second, scale: second_scale_ff,
                        set_last: 1'b0, short_set: 1'b0};
         first_slot = inner_slot;
         end_slot   = inner_slot;
      end else begin
         inner_slot = '{diff: d_central, scale: central_scale_ff,
                        set_last: 1'b0, short_set: 1'b0};
         first_slot = '{diff: d_first, scale: edge_scale_ff,
                        set_last: 1'b0, short_set: 1'b0};
         end_slot   = '{diff: d_end, scale: edge_scale_ff,
                        set_last: 1'b0, short_set: 1'b0};
      end
      end_slot.set_last = 1'b1;

      slot_in[0] = short_slot;
      slot_in[1] = short_slot;
      slot_in[2] = short_slot;
      count_in   = 2'd0;

      unique case (seen_count_ff)
         2'd0: begin
            // a lone sample: nothing to difference against
            slot_in[0].set_last = 1'b1;
            count_in            = req_data.stream_end ? 2'd1 : 2'd0;
         end
         2'd1: begin
            if (req_data.stream_end) begin
               count_in = 2'd2;
               if (!order_mode_ff) begin
                  // two samples: both ends get the one-sided difference
                  slot_in[0]          = end_slot;
                  slot_in[0].set_last = 1'b0;
                  slot_in[1]          = end_slot;
               end else begin
                  slot_in[1].set_last = 1'b1;
               end
            end
         end
         2'd2: begin
            // third sample: emit the leading edge and the first inner point, and the trailing edge if the set ends here
            slot_in[0] = first_slot;
            slot_in[1] = inner_slot;
            slot_in[2] = end_slot;
            count_in   = req_data.stream_end ? 2'd3 : 2'd2;
         end
         default: begin
            slot_in[0] = inner_slot;
            slot_in[1] = end_slot;
            count_in   = req_data.stream_end ? 2'd2 : 2'd1;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Pending slots, drained one per cycle into the output register while it is not stalled
   // ---------------------------------------------------------------------
   slot_type   job_slot_ff [3];
   logic       job_valid_ff;
   logic [1:0] job_count_ff;
   logic [1:0] job_ptr_ff;
   logic       job_load, out_load, emit, job_done, job_run_last;
   slot_type   cur_slot;

   assign out_load     = !rsp_valid || !rsp_stall;
   assign emit         = job_valid_ff && out_load;
   assign job_run_last = (job_ptr_ff == job_count_ff - 2'd1);
   assign job_done     = emit && job_run_last;
   assign req_stall    = job_valid_ff && !job_done;
   assign job_load     = req_accept && (count_in != 2'd0);

   always_comb begin
      unique case (job_ptr_ff)
         2'd0:    cur_slot = job_slot_ff[0];
         2'd1:    cur_slot = job_slot_ff[1];
         default: cur_slot = job_slot_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_ptr_ff   <= '0;
         job_count_ff <= '0;
      end else if (job_load) begin
         job_valid_ff <= 1'b1;
         job_ptr_ff   <= '0;
         job_count_ff <= count_in;
      end else if (job_done) begin
         job_valid_ff <= 1'b0;
      end else if (emit) begin
         job_ptr_ff <= job_ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_slot_ff[0] <= slot_in[0];
         job_slot_ff[1] <= slot_in[1];
         job_slot_ff[2] <= slot_in[2];
      end
   end

   // ---------------------------------------------------------------------
   // Scale, floor shift, saturate
   // ---------------------------------------------------------------------
   logic signed [PROD_BITS-1:0] prod, prod_shift;
   logic signed [WIDE_BITS-1:0] prod_wide;
   logic signed [DERIV_BITS-1:0] deriv_sat;

   assign prod       = cur_slot.diff * $signed({1'b0, cur_slot.scale});
   assign prod_shift = prod >>> SCALE_FRAC_BITS;
   assign prod_wide  = WIDE_BITS'(prod_shift);

   always_comb begin
      priority if (prod_wide > DERIV_MAX) deriv_sat = DERIV_MAX[DERIV_BITS-1:0];
      else if (prod_wide < DERIV_MIN)     deriv_sat = DERIV_MIN[DERIV_BITS-1:0];
      else                                deriv_sat = prod_wide[DERIV_BITS-1:0];
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.derivative <= deriv_sat;
         rsp_data_ff.run_last   <= job_run_last;
         rsp_data_ff.set_last   <= cur_slot.set_last;
         rsp_data_ff.short_set  <= cur_slot.short_set;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_IMPLIES(a_no_stall_when_empty, clock, reset, !job_valid_ff, !req_stall)
   `ASSERT_IMPLIES(a_ptr_in_range, clock, reset, job_valid_ff, job_ptr_ff < job_count_ff)
   `ASSERT_IMPLIES(a_set_last_ends_run, clock, reset, rsp_valid && rsp_data.set_last, rsp_data.run_last)
   `ASSERT_IMPLIES(a_short_is_zero, clock, reset, rsp_valid && rsp_data.short_set, rsp_data.derivative == '0)
   `ASSERT_NEXT(a_end_clears_set, clock, reset, req_accept && req_data.stream_end, seen_count_ff == '0)

endmodule
`default_nettype wire
